FILE: rtl/vcml_pkg.sv
package vcml_pkg;

    localparam int unsigned IN_DATA_W  = 24;
    localparam int unsigned OUT_DATA_W = 40;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] REG_TEMP_LIMIT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT = 1'd1;

    localparam logic signed [8:0] TEMP_LIMIT_RESET  = 9'sd110;
    localparam logic [6:0]        SPEED_LIMIT_RESET = 7'd80;

    localparam logic [3:0] CMD_NONE      = 4'd0;
    localparam logic [3:0] CMD_REARM     = 4'd1;
    localparam logic [3:0] CMD_ACCEL     = 4'd2;
    localparam logic [3:0] CMD_BRAKE     = 4'd3;
    localparam logic [3:0] CMD_LEFT      = 4'd4;
    localparam logic [3:0] CMD_RIGHT     = 4'd5;
    localparam logic [3:0] CMD_AUTO      = 4'd6;
    localparam logic [3:0] CMD_MANUAL    = 4'd7;
    localparam logic [3:0] CMD_SPD_UP    = 4'd8;
    localparam logic [3:0] CMD_SPD_DOWN  = 4'd9;
    localparam logic [3:0] CMD_HDG_LEFT  = 4'd10;
    localparam logic [3:0] CMD_HDG_RIGHT = 4'd11;
    localparam logic [3:0] CMD_GOTO      = 4'd12;

    localparam logic signed [8:0] STEP_DRIVE   = 9'sd5;
    localparam logic signed [8:0] THROTTLE_MAX = 9'sd100;
    localparam logic signed [8:0] THROTTLE_MIN = -9'sd100;
    localparam logic signed [9:0] STEER_STEP   = 10'sd5;
    localparam logic signed [9:0] STEER_MAX    = 10'sd180;
    localparam logic signed [9:0] STEER_MIN    = -10'sd180;
    localparam logic [7:0]        STEP_SPEED   = 8'd5;
    localparam logic signed [9:0] STEP_HEADING = 10'sd10;
    localparam logic signed [9:0] HDG_MAX      = 10'sd180;
    localparam logic signed [9:0] HDG_MIN      = -10'sd180;
    localparam logic signed [9:0] HDG_FULL     = 10'sd360;

    typedef struct packed {
        logic              active;
        logic              raise;
        logic [3:0]        cmd;
        logic signed [8:0] temp;
        logic              elec;
        logic              hyd;
    } item_t;

    typedef struct packed {
        logic              fault;
        logic              auto_on;
        logic              nav;
        logic signed [7:0] throttle;
        logic signed [8:0] steer;
        logic [6:0]        speed;
        logic signed [8:0] heading;
    } state_t;

    typedef struct packed {
        logic signed [8:0] temp_limit;
        logic [6:0]        speed_limit;
    } cfg_t;

endpackage

FILE: rtl/vcml_cfg.sv
module vcml_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [vcml_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [vcml_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    output vcml_pkg::cfg_t                       cfg
);

    vcml_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.temp_limit  <= vcml_pkg::TEMP_LIMIT_RESET;
            cfg_reg.speed_limit <= vcml_pkg::SPEED_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                vcml_pkg::REG_TEMP_LIMIT:  cfg_reg.temp_limit  <= $signed(cfg_wdata);
                vcml_pkg::REG_SPEED_LIMIT: cfg_reg.speed_limit <= cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/vcml_step.sv
module vcml_step (
    input  vcml_pkg::item_t  item,
    input  vcml_pkg::state_t cur,
    input  vcml_pkg::cfg_t   cfg,
    output vcml_pkg::state_t nxt,
    output logic             refused
);

    logic signed [8:0] thr_up;
    logic signed [8:0] thr_dn;
    logic signed [7:0] thr_up_sat;
    logic signed [7:0] thr_dn_sat;
    logic signed [9:0] str_up;
    logic signed [9:0] str_dn;
    logic signed [8:0] str_up_sat;
    logic signed [8:0] str_dn_sat;
    logic [7:0]        spd_up;
    logic [6:0]        spd_up_sat;
    logic [6:0]        spd_dn_sat;
    logic signed [9:0] hdg_l;
    logic signed [9:0] hdg_r;
    logic signed [9:0] hdg_l_wrap;
    logic signed [9:0] hdg_r_wrap;
    logic              safe;

    assign thr_up     = {cur.throttle[7], cur.throttle} + vcml_pkg::STEP_DRIVE;
    assign thr_dn     = {cur.throttle[7], cur.throttle} - vcml_pkg::STEP_DRIVE;
    assign thr_up_sat = (thr_up > vcml_pkg::THROTTLE_MAX) ?
                        vcml_pkg::THROTTLE_MAX[7:0] : thr_up[7:0];
    assign thr_dn_sat = (thr_dn < vcml_pkg::THROTTLE_MIN) ?
                        vcml_pkg::THROTTLE_MIN[7:0] : thr_dn[7:0];

    assign str_up     = {cur.steer[8], cur.steer} + vcml_pkg::STEER_STEP;
    assign str_dn     = {cur.steer[8], cur.steer} - vcml_pkg::STEER_STEP;
    assign str_up_sat = (str_up > vcml_pkg::STEER_MAX) ?
                        vcml_pkg::STEER_MAX[8:0] : str_up[8:0];
    assign str_dn_sat = (str_dn < vcml_pkg::STEER_MIN) ?
                        vcml_pkg::STEER_MIN[8:0] : str_dn[8:0];

    assign spd_up     = {1'b0, cur.speed} + vcml_pkg::STEP_SPEED;
    assign spd_up_sat = (spd_up > {1'b0, cfg.speed_limit}) ? cfg.speed_limit : spd_up[6:0];
    assign spd_dn_sat = ({1'b0, cur.speed} < vcml_pkg::STEP_SPEED) ?
                        7'd0 : (cur.speed - vcml_pkg::STEP_SPEED[6:0]);

    assign hdg_l      = {cur.heading[8], cur.heading} - vcml_pkg::STEP_HEADING;
    assign hdg_r      = {cur.heading[8], cur.heading} + vcml_pkg::STEP_HEADING;
    assign hdg_l_wrap = (hdg_l < vcml_pkg::HDG_MIN) ? (hdg_l + vcml_pkg::HDG_FULL) : hdg_l;
    assign hdg_r_wrap = (hdg_r > vcml_pkg::HDG_MAX) ? (hdg_r - vcml_pkg::HDG_FULL) : hdg_r;

    assign safe = (item.temp <= cfg.temp_limit) && !item.elec && !item.hyd;

    always_comb
    begin
        nxt     = cur;
        refused = 1'b0;
        if (item.active)
        begin
            if (item.raise)
            begin
                nxt.fault = 1'b1;
            end
            if (nxt.fault)
            begin
                nxt.auto_on  = 1'b0;
                nxt.nav      = 1'b0;
                nxt.throttle = '0;
            end
            if (item.cmd == vcml_pkg::CMD_REARM)
            begin
                if (nxt.fault)
                begin
                    if (safe)
                    begin
                        nxt.fault = 1'b0;
                    end
                    else
                    begin
                        refused = 1'b1;
                    end
                end
            end
            else if (!nxt.fault && item.cmd != vcml_pkg::CMD_NONE)
            begin
                if (!cur.auto_on)
                begin
                    case (item.cmd)
                        vcml_pkg::CMD_ACCEL: nxt.throttle = thr_up_sat;
                        vcml_pkg::CMD_BRAKE: nxt.throttle = thr_dn_sat;
                        vcml_pkg::CMD_LEFT:  nxt.steer    = str_dn_sat;
                        vcml_pkg::CMD_RIGHT: nxt.steer    = str_up_sat;
                        default: ;
                    endcase
                end
                case (item.cmd)
                    vcml_pkg::CMD_AUTO:
                    begin
                        nxt.auto_on = 1'b1;
                    end
                    vcml_pkg::CMD_MANUAL:
                    begin
                        nxt.auto_on = 1'b0;
                        nxt.nav     = 1'b0;
                    end
                    vcml_pkg::CMD_SPD_UP:    nxt.speed   = spd_up_sat;
                    vcml_pkg::CMD_SPD_DOWN:  nxt.speed   = spd_dn_sat;
                    vcml_pkg::CMD_HDG_LEFT:  nxt.heading = hdg_l_wrap[8:0];
                    vcml_pkg::CMD_HDG_RIGHT: nxt.heading = hdg_r_wrap[8:0];
                    vcml_pkg::CMD_GOTO:
                    begin
                        nxt.nav     = 1'b1;
                        nxt.auto_on = 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

FILE: rtl/vehicle_command_mode_logic_core.sv
// An accepted item passes the input register, then the result register, to m_tdata.
// Throughput: one item per cycle; the input register, the state update and the
// result register all advance together whenever the result register is free or taken.
// Reset: rst_n is asynchronous and active low; it empties both registers, clears all
// mode flags and setpoints, and loads temp_limit 110 and speed_limit 80.
module vehicle_command_mode_logic_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // Fields from bit 0: system_active, fault_raise, command[3:0], temperature[8:0],
    // electrical_fault, hydraulic_fault, zero fill.
    input  logic [vcml_pkg::IN_DATA_W-1:0]        s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // Fields from bit 0: fault_active, auto_mode, navigation_on, throttle_cmd[7:0],
    // steer_cmd[8:0], speed_setpoint[6:0], heading_setpoint[8:0], rearm_refused,
    // zero fill.
    output logic [vcml_pkg::OUT_DATA_W-1:0]       m_tdata,
    input  logic                                  cfg_we,
    input  logic [vcml_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [vcml_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

    vcml_pkg::cfg_t   cfg;
    vcml_pkg::item_t  in_reg;
    logic             in_valid_reg;
    vcml_pkg::state_t st_reg;
    vcml_pkg::state_t st_next;
    logic             refused_next;
    vcml_pkg::state_t out_st_reg;
    logic             out_refused_reg;
    logic             out_valid_reg;
    logic             advance;
    vcml_pkg::item_t  s_item;

    assign s_item.active = s_tdata[0];
    assign s_item.raise  = s_tdata[1];
    assign s_item.cmd    = s_tdata[5:2];
    assign s_item.temp   = $signed(s_tdata[14:6]);
    assign s_item.elec   = s_tdata[15];
    assign s_item.hyd    = s_tdata[16];

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    vcml_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    vcml_step u_step (
        .item    (in_reg),
        .cur     (st_reg),
        .cfg     (cfg),
        .nxt     (st_next),
        .refused (refused_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_reg <= s_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                st_reg <= st_next;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_st_reg      <= st_next;
            out_refused_reg <= refused_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000,
                       out_refused_reg,
                       out_st_reg.heading,
                       out_st_reg.speed,
                       out_st_reg.steer,
                       out_st_reg.throttle,
                       out_st_reg.nav,
                       out_st_reg.auto_on,
                       out_st_reg.fault};

    a_fault_forces_manual: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.fault |-> (!st_reg.auto_on && !st_reg.nav && st_reg.throttle == 8'sd0))
        else $error("Fault latch set while automatic mode, navigation or throttle active.");

    a_raise_latches: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_reg.active && in_reg.raise && in_reg.cmd != vcml_pkg::CMD_REARM)
        |=> st_reg.fault)
        else $error("Fault raise did not set the fault latch.");

    a_throttle_range: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg.throttle <= 8'sd100) && (st_reg.throttle >= -8'sd100))
        else $error("Throttle left its clamp range.");

    a_refused_faulted: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_refused_reg) |-> out_st_reg.fault)
        else $error("Rearm refusal reported without an active fault.");

    a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("Input stalled although the result register is empty.");

endmodule
